/* sv/e2dcm_pkg.sv */
// e2dcm_pkg: types, fixed-point format and arithmetic helpers for the
// euler_to_direction_cosine_matrix block; used by every file of the block
// depends on nothing
package e2dcm_pkg;

    // fixed-point format of every field
    localparam int DATA_WIDTH = 16;
    localparam int FRAC_BITS  = 14;

    // full product and growth room for one add after scaling
    localparam int PROD_WIDTH = 2 * DATA_WIDTH;
    localparam int SUM_WIDTH  = PROD_WIDTH + 1;

    typedef logic signed [DATA_WIDTH-1:0] data_t;
    typedef logic signed [PROD_WIDTH-1:0] prod_t;
    typedef logic signed [SUM_WIDTH-1:0]  sum_t;

    // largest and smallest value of a field, at sum width
    localparam sum_t SAT_MAX = sum_t'({1'b0, {(DATA_WIDTH-1){1'b1}}});
    localparam sum_t SAT_MIN = ~SAT_MAX;

    // one input request: sines and cosines of the three angles
    typedef struct packed {
        data_t sin_pitch;
        data_t cos_pitch;
        data_t sin_roll;
        data_t cos_roll;
        data_t sin_yaw;
        data_t cos_yaw;
    } in_t;

    // one result request: the nine matrix entries
    typedef struct packed {
        data_t m00;
        data_t m01;
        data_t m02;
        data_t m10;
        data_t m11;
        data_t m12;
        data_t m20;
        data_t m21;
        data_t m22;
    } out_t;

    // hand-off between the scale-and-saturate stage and the combine stages
    typedef struct packed {
        data_t p1;
        data_t p2;
        data_t p3;
        data_t p4;
        data_t sin_pitch;
        data_t m02;
        data_t m10;
        data_t m11;
        data_t m12;
        data_t m22;
    } mid_t;

    // full signed product of two fields
    function automatic prod_t fx_mul(data_t a, data_t b);
        return prod_t'(a) * prod_t'(b);
    endfunction

    // drop the fraction bits, rounding toward minus infinity
    function automatic sum_t fx_scale(prod_t p);
        sum_t s;
        s = {p[PROD_WIDTH-1], p};
        return s >>> FRAC_BITS;
    endfunction

    // sign-extend a field to sum width
    function automatic sum_t fx_ext(data_t d);
        return sum_t'(d);
    endfunction

    // clamp to the field range
    function automatic data_t fx_sat(sum_t v);
        sum_t c;
        if (v > SAT_MAX) begin
            c = SAT_MAX;
        end else if (v < SAT_MIN) begin
            c = SAT_MIN;
        end else begin
            c = v;
        end
        return c[DATA_WIDTH-1:0];
    endfunction

endpackage

/* sv/e2dcm_combine.sv */
// e2dcm_combine: second multiply by the pitch sine and the final add and
// saturate for the four mixed entries; output register of the block
// depends on e2dcm_pkg
module e2dcm_combine (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  e2dcm_pkg::mid_t   in_data,
    output logic              m_valid,
    input  logic              m_ready,
    output e2dcm_pkg::out_t   m_data
);

    // products of the shared terms with the pitch sine
    typedef struct packed {
        e2dcm_pkg::prod_t p4_sp;
        e2dcm_pkg::prod_t p2_sp;
        e2dcm_pkg::prod_t p1_sp;
        e2dcm_pkg::prod_t p3_sp;
        e2dcm_pkg::mid_t  mid;
    } mix_t;

    logic            v3_reg;
    logic            v4_reg;
    logic            ready3;
    logic            ready4;
    mix_t            mix_reg;
    mix_t            mix_next;
    e2dcm_pkg::out_t out_reg;
    e2dcm_pkg::out_t out_next;

    // per-stage flow control
    assign ready4   = !v4_reg || m_ready;
    assign ready3   = !v3_reg || ready4;
    assign in_ready = ready3;

    // stage 3: multiply shared terms by the pitch sine
    always_comb begin
        mix_next.p4_sp = e2dcm_pkg::fx_mul(in_data.p4, in_data.sin_pitch);
        mix_next.p2_sp = e2dcm_pkg::fx_mul(in_data.p2, in_data.sin_pitch);
        mix_next.p1_sp = e2dcm_pkg::fx_mul(in_data.p1, in_data.sin_pitch);
        mix_next.p3_sp = e2dcm_pkg::fx_mul(in_data.p3, in_data.sin_pitch);
        mix_next.mid   = in_data;
    end

    // stage 4: scale, combine, saturate
    always_comb begin
        out_next.m00 = e2dcm_pkg::fx_sat(e2dcm_pkg::fx_ext(mix_reg.mid.p3)
                                         - e2dcm_pkg::fx_scale(mix_reg.p4_sp));
        out_next.m01 = e2dcm_pkg::fx_sat(e2dcm_pkg::fx_ext(mix_reg.mid.p1)
                                         + e2dcm_pkg::fx_scale(mix_reg.p2_sp));
        out_next.m20 = e2dcm_pkg::fx_sat(e2dcm_pkg::fx_ext(mix_reg.mid.p2)
                                         + e2dcm_pkg::fx_scale(mix_reg.p1_sp));
        out_next.m21 = e2dcm_pkg::fx_sat(e2dcm_pkg::fx_ext(mix_reg.mid.p4)
                                         - e2dcm_pkg::fx_scale(mix_reg.p3_sp));
        out_next.m02 = mix_reg.mid.m02;
        out_next.m10 = mix_reg.mid.m10;
        out_next.m11 = mix_reg.mid.m11;
        out_next.m12 = mix_reg.mid.m12;
        out_next.m22 = mix_reg.mid.m22;
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (ready3) begin
                v3_reg <= in_valid;
            end
            if (ready4) begin
                v4_reg <= v3_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (ready3 && in_valid) begin
            mix_reg <= mix_next;
        end
        if (ready4 && v3_reg) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = v4_reg;
    assign m_data  = out_reg;

endmodule

/* sv/euler_to_direction_cosine_matrix.sv */
// euler_to_direction_cosine_matrix: y-x-z direction cosine matrix from the
// sines and cosines of pitch, roll and yaw, four-stage pipeline
// depends on e2dcm_pkg and e2dcm_combine
//
//  channel | ports                     | payload           | accepted when
//  --------+---------------------------+-------------------+------------------------
//  input   | s_valid s_ready s_data    | e2dcm_pkg::in_t   | s_valid && s_ready
//  result  | m_valid m_ready m_data    | e2dcm_pkg::out_t  | m_valid && m_ready
//
// one request enters per cycle while s_ready is high, through four register
// stages: product bank, scale and saturate, multiply by pitch sine, combine.
// its result is offered from the output register of the combine stage.
// reset clears only the four stage valid bits.
// a stall on the result side holds each full stage with no empty stage after
// it; empty stages still fill, so s_ready stays high until every stage holds a request.
module euler_to_direction_cosine_matrix (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  e2dcm_pkg::in_t    s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output e2dcm_pkg::out_t   m_data
);

    // stage 1 contents: all first-level products
    typedef struct packed {
        e2dcm_pkg::prod_t cr_sy;
        e2dcm_pkg::prod_t sr_cy;
        e2dcm_pkg::prod_t cr_cy;
        e2dcm_pkg::prod_t sr_sy;
        e2dcm_pkg::prod_t sr_cp;
        e2dcm_pkg::prod_t cp_sy;
        e2dcm_pkg::prod_t cp_cy;
        e2dcm_pkg::prod_t cr_cp;
        e2dcm_pkg::data_t sin_pitch;
    } prod_stage_t;

    logic             v1_reg;
    logic             v2_reg;
    logic             ready1;
    logic             ready2;
    logic             mid_ready;
    prod_stage_t      prod_reg;
    prod_stage_t      prod_next;
    e2dcm_pkg::mid_t  mid_reg;
    e2dcm_pkg::mid_t  mid_next;

    // per-stage flow control
    assign ready2  = !v2_reg || mid_ready;
    assign ready1  = !v1_reg || ready2;
    assign s_ready = ready1;

    // stage 1: product bank
    always_comb begin
        prod_next.cr_sy     = e2dcm_pkg::fx_mul(s_data.cos_roll,  s_data.sin_yaw);
        prod_next.sr_cy     = e2dcm_pkg::fx_mul(s_data.sin_roll,  s_data.cos_yaw);
        prod_next.cr_cy     = e2dcm_pkg::fx_mul(s_data.cos_roll,  s_data.cos_yaw);
        prod_next.sr_sy     = e2dcm_pkg::fx_mul(s_data.sin_roll,  s_data.sin_yaw);
        prod_next.sr_cp     = e2dcm_pkg::fx_mul(s_data.sin_roll,  s_data.cos_pitch);
        prod_next.cp_sy     = e2dcm_pkg::fx_mul(s_data.cos_pitch, s_data.sin_yaw);
        prod_next.cp_cy     = e2dcm_pkg::fx_mul(s_data.cos_pitch, s_data.cos_yaw);
        prod_next.cr_cp     = e2dcm_pkg::fx_mul(s_data.cos_roll,  s_data.cos_pitch);
        prod_next.sin_pitch = s_data.sin_pitch;
    end

    // stage 2: scale and saturate shared terms and single-product entries
    always_comb begin
        mid_next.p1  = e2dcm_pkg::fx_sat(e2dcm_pkg::fx_scale(prod_reg.cr_sy));
        mid_next.p2  = e2dcm_pkg::fx_sat(e2dcm_pkg::fx_scale(prod_reg.sr_cy));
        mid_next.p3  = e2dcm_pkg::fx_sat(e2dcm_pkg::fx_scale(prod_reg.cr_cy));
        mid_next.p4  = e2dcm_pkg::fx_sat(e2dcm_pkg::fx_scale(prod_reg.sr_sy));
        mid_next.sin_pitch = prod_reg.sin_pitch;
        mid_next.m02 = e2dcm_pkg::fx_sat(-e2dcm_pkg::fx_scale(prod_reg.sr_cp));
        mid_next.m10 = e2dcm_pkg::fx_sat(-e2dcm_pkg::fx_scale(prod_reg.cp_sy));
        mid_next.m11 = e2dcm_pkg::fx_sat(e2dcm_pkg::fx_scale(prod_reg.cp_cy));
        mid_next.m12 = prod_reg.sin_pitch;
        mid_next.m22 = e2dcm_pkg::fx_sat(e2dcm_pkg::fx_scale(prod_reg.cr_cp));
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (ready1) begin
                v1_reg <= s_valid;
            end
            if (ready2) begin
                v2_reg <= v1_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (ready1 && s_valid) begin
            prod_reg <= prod_next;
        end
        if (ready2 && v1_reg) begin
            mid_reg <= mid_next;
        end
    end

    // stages 3 and 4
    e2dcm_combine u_combine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (v2_reg),
        .in_ready (mid_ready),
        .in_data  (mid_reg),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule
